@@ sv/ordered_queue_remove_by_key_macros.svh @@
// assertion macros for the checker file
`ifndef ORDERED_QUEUE_REMOVE_BY_KEY_MACROS_SVH
`define ORDERED_QUEUE_REMOVE_BY_KEY_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define OQRK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oqrk checker: same-cycle rule violated");

// next-cycle implication, sampled on clk, off while rst_n is low
`define OQRK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oqrk checker: next-cycle rule violated");

`endif

@@ sv/oqrk_pkg.sv @@
package oqrk_pkg;

    localparam int DEPTH_DEF   = 32;
    localparam int ID_BITS_DEF = 20;

    typedef enum logic [1:0]
    {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0]
    {
        STAT_DONE     = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_NOTFOUND = 3'd2,
        STAT_ENTRY    = 3'd3,
        STAT_EMPTY    = 3'd4
    } status_t;

    // what every cell does on the coming edge
    typedef enum logic [1:0]
    {
        MODE_HOLD   = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_ROTATE = 2'd3
    } cell_mode_t;

    typedef enum logic
    {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

endpackage

@@ sv/oqrk_cell.sv @@
module oqrk_cell #(
    parameter int INDEX   = 0,
    parameter int DEPTH   = oqrk_pkg::DEPTH_DEF,
    parameter int ID_BITS = oqrk_pkg::ID_BITS_DEF,
    parameter int CNT_W   = $clog2(DEPTH + 1)
) (
    input  logic                      clk,
    input  oqrk_pkg::cell_mode_t      mode,
    input  logic [CNT_W-1:0]          count,
    input  logic [ID_BITS-1:0]        key,
    input  logic [ID_BITS-1:0]        next_data,
    input  logic [ID_BITS-1:0]        head_data,
    input  logic                      hit_in,
    output logic                      hit_out,
    output logic [ID_BITS-1:0]        data
);

    localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_IDX_1 = CNT_W'(INDEX + 1);

    logic [ID_BITS-1:0] data_reg;
    logic [ID_BITS-1:0] data_next;
    logic               load;
    logic               occupied;
    logic               is_tail;

    assign occupied = MY_IDX < count;
    assign is_tail  = MY_IDX_1 == count;
    assign hit_out  = hit_in | (occupied && (data_reg == key));
    assign data     = data_reg;

    always_comb
    begin
        load      = 1'b0;
        data_next = next_data;
        unique case (mode)
            oqrk_pkg::MODE_HOLD:
            begin
                load = 1'b0;
            end
            oqrk_pkg::MODE_APPEND:
            begin
                load      = MY_IDX == count;
                data_next = key;
            end
            oqrk_pkg::MODE_REMOVE:
            begin
                // match here or nearer the head: pull up from behind
                load = hit_out;
            end
            oqrk_pkg::MODE_ROTATE:
            begin
                load      = occupied;
                data_next = is_tail ? head_data : next_data;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ sv/ordered_queue_remove_by_key.sv @@
// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// in      | in_valid, in_ready, opcode, id_value      | sink
// out     | out_valid, out_ready, status, entry_id, last | source
//
// append, remove, empty readout and the unused opcode each give one answer word,
// formed by the hit ripple down the row of cells and the single output register
// a readout first loads the count, then gives one entry per cycle while the
// output slot is free, as the row rotates once, leaving the queue as it was
// reset clears the count and the control; cell contents stay undefined, no sweep
// out_ready low while a word is up holds the output word and keeps in_ready low
module ordered_queue_remove_by_key #(
    parameter int DEPTH   = oqrk_pkg::DEPTH_DEF,
    parameter int ID_BITS = oqrk_pkg::ID_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [ID_BITS-1:0] id_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [ID_BITS-1:0] entry_id,
    output logic               last
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // control state
    oqrk_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     left_reg, left_next;
    logic                 out_valid_reg, out_valid_next;

    // output word, no reset needed
    oqrk_pkg::status_t    status_reg, status_next;
    logic [ID_BITS-1:0]   entry_reg, entry_next;
    logic                 last_reg, last_next;

    // row of cells
    oqrk_pkg::cell_mode_t cell_mode;
    logic [ID_BITS-1:0]   cell_data [DEPTH];
    logic [ID_BITS-1:0]   cell_next [DEPTH];
    logic [DEPTH:0]       hit_chain;

    logic                 slot_free;
    logic                 found;
    logic                 full;

    assign hit_chain[0] = 1'b0;
    assign found        = hit_chain[DEPTH];
    assign full         = count_reg == CNT_FULL;
    // output slot empties this cycle or is already empty
    assign slot_free    = !out_valid_reg || out_ready;
    assign in_ready     = (state_reg == oqrk_pkg::S_IDLE) && slot_free;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            // the tail cell has nobody behind it
            if (gi == DEPTH - 1)
            begin : g_end
                assign cell_next[gi] = '0;
            end
            else
            begin : g_mid
                assign cell_next[gi] = cell_data[gi + 1];
            end

            oqrk_cell #(
                .INDEX   (gi),
                .DEPTH   (DEPTH),
                .ID_BITS (ID_BITS),
                .CNT_W   (CNT_W)
            ) u_cell (
                .clk       (clk),
                .mode      (cell_mode),
                .count     (count_reg),
                .key       (id_value),
                .next_data (cell_next[gi]),
                .head_data (cell_data[0]),
                .hit_in    (hit_chain[gi]),
                .hit_out   (hit_chain[gi + 1]),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oqrk_pkg::S_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        entry_reg  <= entry_next;
        last_reg   <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        entry_next     = entry_reg;
        last_next      = last_reg;
        cell_mode      = oqrk_pkg::MODE_HOLD;

        unique case (state_reg)
            oqrk_pkg::S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    // single-word answer unless a readout starts
                    out_valid_next = 1'b1;
                    status_next    = oqrk_pkg::STAT_DONE;
                    entry_next     = '0;
                    last_next      = 1'b1;
                    unique case (oqrk_pkg::op_t'(opcode))
                        oqrk_pkg::OP_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = oqrk_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cell_mode  = oqrk_pkg::MODE_APPEND;
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                        oqrk_pkg::OP_REMOVE:
                        begin
                            if (found)
                            begin
                                cell_mode  = oqrk_pkg::MODE_REMOVE;
                                count_next = count_reg - CNT_ONE;
                            end
                            else
                            begin
                                status_next = oqrk_pkg::STAT_NOTFOUND;
                            end
                        end
                        oqrk_pkg::OP_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = oqrk_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                left_next      = count_reg;
                                state_next     = oqrk_pkg::S_READ;
                            end
                        end
                        default:
                        begin
                            // unused opcode: plain done word
                            status_next = oqrk_pkg::STAT_DONE;
                        end
                    endcase
                end
            end
            oqrk_pkg::S_READ:
            begin
                if (slot_free)
                begin
                    // head goes out, row rotates so the queue comes back intact
                    out_valid_next = 1'b1;
                    status_next    = oqrk_pkg::STAT_ENTRY;
                    entry_next     = cell_data[0];
                    last_next      = left_reg == CNT_ONE;
                    cell_mode      = oqrk_pkg::MODE_ROTATE;
                    left_next      = left_reg - CNT_ONE;
                    if (left_reg == CNT_ONE)
                    begin
                        state_next = oqrk_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = oqrk_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign entry_id  = entry_reg;
    assign last      = last_reg;

endmodule

@@ sv/oqrk_checker.sv @@
`include "ordered_queue_remove_by_key_macros.svh"

module oqrk_checker #(
    parameter int ID_BITS = oqrk_pkg::ID_BITS_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         opcode,
    input logic [ID_BITS-1:0] id_value,
    input logic               out_valid,
    input logic               out_ready,
    input logic [2:0]         status,
    input logic [ID_BITS-1:0] entry_id,
    input logic               last
);

    // offered input word stays up and unchanged until taken
    `OQRK_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(opcode) && $stable(id_value))

    // stalled output word stays up
    `OQRK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // anything but a queue entry is a lone word
    `OQRK_ASSERT_NOW(a_single_last, out_valid && (status != oqrk_pkg::STAT_ENTRY), last)

    // non-entry words carry a zero id
    `OQRK_ASSERT_NOW(a_zero_id, out_valid && (status != oqrk_pkg::STAT_ENTRY),
        entry_id == '0)

    // mid-readout no new word is taken
    `OQRK_ASSERT_NOW(a_read_busy,
        out_valid && (status == oqrk_pkg::STAT_ENTRY) && !last, !in_ready)

endmodule

bind ordered_queue_remove_by_key oqrk_checker #(
    .ID_BITS (ID_BITS)
) u_oqrk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .id_value  (id_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .entry_id  (entry_id),
    .last      (last)
);

@@ verif/tb.sv @@
`timescale 1ns / 100ps

// self-checking bench for the ordered queue with removal by key
// - a scoreboard object keeps its own copy of the queue and predicts
//   the result words of every accepted input word
// - plain tasks drive the input channel; the output channel is paced by its
//   own process with random stalls and one long hold-off
module tb;

    localparam int DEPTH       = oqrk_pkg::DEPTH_DEF;
    localparam int ID_W        = oqrk_pkg::ID_BITS_DEF;
    localparam int WORD_TARGET = 370;
    localparam int HOLD_LEN    = 150;     // long receiver hold-off, in cycles
    localparam int TAIL_CYCLES = 40;      // settle time once nothing is due
    localparam int CYCLE_LIMIT = 600000;  // several times the slowest clean run
    localparam int MAX_SHOWN   = 10;

    // one predicted result word
    typedef struct packed
    {
        oqrk_pkg::status_t st;
        logic [ID_W-1:0]   id;
        logic              last;
    } result_t;

    // scoreboard: shadow queue plus the list of result words still due
    class queue_scoreboard;
        logic [ID_W-1:0] cells[$];
        result_t         due[$];
        int              mismatches;
        int              checked;
        int              readouts;
        int              drops;
        int              misses;
        int              removals;

        function void add_result(oqrk_pkg::status_t st, logic [ID_W-1:0] id, logic last);
            result_t r;
            r.st   = st;
            r.id   = id;
            r.last = last;
            due.push_back(r);
        endfunction

        // work out the result words of one accepted input word
        function void note_word(oqrk_pkg::op_t op, logic [ID_W-1:0] key);
            int hit;
            int i;
            hit = -1;
            case (op)
                oqrk_pkg::OP_APPEND:
                begin
                    if (cells.size() >= DEPTH)
                    begin
                        drops++;
                        add_result(oqrk_pkg::STAT_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        cells.push_back(key);
                        add_result(oqrk_pkg::STAT_DONE, '0, 1'b1);
                    end
                end
                oqrk_pkg::OP_REMOVE:
                begin
                    for (i = 0; i < cells.size(); i++)
                    begin
                        if (cells[i] == key)
                        begin
                            hit = i;
                            break;
                        end
                    end
                    if (hit < 0)
                    begin
                        misses++;
                        add_result(oqrk_pkg::STAT_NOTFOUND, '0, 1'b1);
                    end
                    else
                    begin
                        removals++;
                        cells.delete(hit);
                        add_result(oqrk_pkg::STAT_DONE, '0, 1'b1);
                    end
                end
                oqrk_pkg::OP_READ:
                begin
                    readouts++;
                    if (cells.size() == 0)
                        add_result(oqrk_pkg::STAT_EMPTY, '0, 1'b1);
                    else
                        for (i = 0; i < cells.size(); i++)
                            add_result(oqrk_pkg::STAT_ENTRY, cells[i],
                                       i == cells.size() - 1);
                end
                default:
                    add_result(oqrk_pkg::STAT_DONE, '0, 1'b1);
            endcase
        endfunction

        // compare one accepted result word with the oldest one due
        function void check_word(logic [2:0] st, logic [ID_W-1:0] id, logic last);
            result_t want;
            checked++;
            if (due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("tb: unexpected word status %0d id %05h last %0b",
                             st, id, last);
                return;
            end
            want = due.pop_front();
            if (st !== want.st || id !== want.id || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("tb: mismatch status %0d/%0d id %05h/%05h last %0b/%0b (exp/act)",
                             want.st, st, want.id, id, want.last, last);
            end
        endfunction
    endclass

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_ready;
    logic [1:0]      opcode    = oqrk_pkg::OP_APPEND;
    logic [ID_W-1:0] id_value  = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic [2:0]      status;
    logic [ID_W-1:0] entry_id;
    logic            last;

    queue_scoreboard sb;
    int              cycle_count = 0;
    int              words_sent  = 0;
    int              gap_max     = 0;  // sender idle cycles per word, upper bound
    int              stall_max   = 0;  // receiver stall cycles per word, upper bound
    int              hold_len    = 0;  // pending long hold-off for the receiver
    logic [ID_W-1:0] id_pool[8];       // small set of ids so that removals hit

    ordered_queue_remove_by_key #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .id_value  (id_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .entry_id  (entry_id),
        .last      (last)
    );

    always #5 clk = ~clk;

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // every result word taken by the receiver is checked at the edge it moves
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(status, entry_id, last);
    end

    // pool ids, full-range values and extremes in equal shares
    function automatic logic [ID_W-1:0] rand_id();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return ID_W'($urandom_range(0, (1 << ID_W) - 1));
            default: return id_pool[$urandom_range(0, 7)];
        endcase
    endfunction

    // offer one word after a random gap and hold it until it is taken;
    // valid is only lowered when a gap really follows, so back-to-back
    // words never see valid dropped and raised in one step
    task automatic send_word(input oqrk_pkg::op_t op, input logic [ID_W-1:0] key);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        id_value <= key;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(op, key);
        words_sent++;
    endtask

    // sender pause: valid drops, nothing goes in until every due word has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.due.size() != 0);
    endtask

    // receiver: random stall per word, or the long hold-off when one is asked;
    // ready stays high until a word actually moves
    initial
    begin : receiver
        int stall;
        forever
        begin
            stall = $urandom_range(0, stall_max);
            if (hold_len > 0)
            begin
                stall    = hold_len;
                hold_len = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin : stimulus
        int              i;
        int              kind;
        int              burst;
        bit              paused;
        logic [ID_W-1:0] key;

        sb     = new();
        paused = 1'b0;
        for (i = 0; i < 8; i++)
            id_pool[i] = ID_W'($urandom_range(0, (1 << ID_W) - 1));

        // hold reset, then release it on an edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling on either side
        send_word(oqrk_pkg::OP_READ, 20'h12345);    // empty readout, id ignored
        send_word(oqrk_pkg::OP_REMOVE, '0);         // miss on an empty queue
        send_word(oqrk_pkg::OP_APPEND, '0);
        send_word(oqrk_pkg::OP_APPEND, '1);
        send_word(oqrk_pkg::OP_APPEND, 20'h5A5A5);
        send_word(oqrk_pkg::OP_APPEND, 20'hA5A5A);
        send_word(oqrk_pkg::OP_APPEND, 20'h5A5A5);  // duplicate id
        send_word(oqrk_pkg::OP_NONE, '1);           // unused opcode, queue untouched
        send_word(oqrk_pkg::OP_READ, '0);
        send_word(oqrk_pkg::OP_REMOVE, 20'h5A5A5);  // only the copy nearest the head goes
        send_word(oqrk_pkg::OP_READ, '1);
        send_word(oqrk_pkg::OP_REMOVE, 20'h00001);  // absent id
        send_word(oqrk_pkg::OP_REMOVE, '0);         // head entry
        send_word(oqrk_pkg::OP_REMOVE, 20'h5A5A5);  // tail entry
        send_word(oqrk_pkg::OP_READ, '0);
        send_word(oqrk_pkg::OP_REMOVE, '1);
        send_word(oqrk_pkg::OP_REMOVE, 20'hA5A5A);  // last entry, queue empty again
        send_word(oqrk_pkg::OP_READ, '0);
        send_word(oqrk_pkg::OP_NONE, '0);

        // pressure: receiver holds off while the queue is filled past full,
        // so the output word backs up and input stalls; full drops at the end
        hold_len = HOLD_LEN;
        while (sb.cells.size() < DEPTH)
            send_word(oqrk_pkg::OP_APPEND, rand_id());
        send_word(oqrk_pkg::OP_APPEND, rand_id());
        send_word(oqrk_pkg::OP_APPEND, '1);
        send_word(oqrk_pkg::OP_READ, '0);            // full readout, 32 entries
        wait_drained();

        // random part: mostly well-formed sequences with random content
        while (words_sent < WORD_TARGET)
        begin
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 8;
            stall_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            kind      = $urandom_range(0, 11);
            burst     = $urandom_range(1, 6);
            case (kind)
                0:
                begin
                    // fill to the brim, sometimes push past it, then read back
                    while (sb.cells.size() < DEPTH)
                        send_word(oqrk_pkg::OP_APPEND, rand_id());
                    if ($urandom_range(0, 1))
                        send_word(oqrk_pkg::OP_APPEND, rand_id());
                    send_word(oqrk_pkg::OP_READ, rand_id());
                end
                1, 2, 3, 4:
                begin
                    // removals that hit: head, tail or anywhere in between
                    repeat (burst)
                    begin
                        if (sb.cells.size() == 0)
                            send_word(oqrk_pkg::OP_APPEND, rand_id());
                        else
                        begin
                            case ($urandom_range(0, 2))
                                0:       key = sb.cells[0];
                                1:       key = sb.cells[sb.cells.size() - 1];
                                default: key = sb.cells[$urandom_range(0, sb.cells.size() - 1)];
                            endcase
                            send_word(oqrk_pkg::OP_REMOVE, key);
                        end
                    end
                end
                5, 6, 7:
                begin
                    // append bursts from the pool, giving duplicates
                    repeat (burst)
                        send_word(oqrk_pkg::OP_APPEND, rand_id());
                end
                8, 9:
                    send_word(oqrk_pkg::OP_READ, rand_id());
                default:
                begin
                    // noise: any opcode, any id, mostly misses on removal
                    repeat (burst)
                        send_word(oqrk_pkg::op_t'($urandom_range(0, 3)),
                                  ID_W'($urandom_range(0, (1 << ID_W) - 1)));
                end
            endcase

            // one mid-run pause with the queue drained of due words
            if (!paused && words_sent > WORD_TARGET / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
        end

        // wind down: stop offering, let everything arrive, then settle
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d words in, %0d result words checked, %0d readouts",
                 words_sent, sb.checked, sb.readouts);
        $display("tb: %0d removals, %0d misses, %0d full drops, %0d cycles",
                 sb.removals, sb.misses, sb.drops, cycle_count);
        if (sb.mismatches == 0 && sb.due.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/oqrk_pkg.sv
sv/oqrk_cell.sv
sv/ordered_queue_remove_by_key.sv
sv/oqrk_checker.sv
verif/tb.sv
